// ===== hdl/dtc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types, codes and helpers for the dual-rate time-of-day counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtc_pkg;

    // Running-time pulse divider, in normal seconds.
    localparam int unsigned RUN_TIME_DIVIDER = 1;

    // Command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_HOUR_INC = 3'd1;
    localparam logic [2:0] CMD_HOUR_DEC = 3'd2;
    localparam logic [2:0] CMD_MIN_INC  = 3'd3;
    localparam logic [2:0] CMD_SEC_CLR  = 3'd4;

    // External clock write codes
    localparam logic [1:0] RTC_WR_NONE  = 2'd0;
    localparam logic [1:0] RTC_WR_HOURS = 2'd1;
    localparam logic [1:0] RTC_WR_MINS  = 2'd2;
    localparam logic [1:0] RTC_WR_SECS  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_TICKS_PER_SEC = 3'd0;
    localparam logic [2:0] CFG_SECS_PER_MIN  = 3'd1;
    localparam logic [2:0] CFG_MINS_PER_HOUR = 3'd2;
    localparam logic [2:0] CFG_HOURS_PER_DAY = 3'd3;
    localparam logic [2:0] CFG_TRICK_MODE    = 3'd4;

    typedef struct packed {
        logic [7:0] ticks_per_second;
        logic [7:0] secs_per_minute;
        logic [7:0] mins_per_hour;
        logic [7:0] hours_per_day;
        logic       set_trick_mode;
    } t_cfg;

    typedef struct packed {
        logic [7:0] norm_tick;
        logic [7:0] norm_sec;
        logic [7:0] norm_min;
        logic [7:0] norm_hour;
        logic [7:0] fast_tick;
        logic [7:0] fast_sec;
        logic [7:0] fast_min;
        logic [7:0] fast_hour;
    } t_tod_state;

    typedef struct packed {
        logic       run_pulse;
        logic       save_pulse;
        logic [1:0] wcode;
    } t_flags;

    // Increment modulo 256, then clear at or above the limit.
    function automatic logic [7:0] wrap_up(input logic [7:0] v, input logic [7:0] lim);
        logic [7:0] s;
        s = v + 8'd1;
        return (s >= lim) ? 8'd0 : s;
    endfunction

    // Decrement modulo 256, then clamp to limit-1 at or above the limit.
    function automatic logic [7:0] wrap_down(input logic [7:0] v, input logic [7:0] lim);
        logic [7:0] s;
        s = v - 8'd1;
        return (s >= lim) ? (lim - 8'd1) : s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dtc_next.sv =====
// ----------------------------------------------------------------------------
// dtc_next
// Next-state and status logic for both time cascades, one item per pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_next
    import dtc_pkg::*;
(
    input  t_cfg       i_cfg,
    input  t_tod_state i_state,
    input  logic [2:0] i_command,
    input  logic [7:0] i_rtc_seconds,
    output t_tod_state o_state,
    output t_flags     o_flags
);

    logic [7:0] w_norm_tick_inc;
    logic [7:0] w_fast_tick_inc;
    logic [7:0] w_fast_term;
    logic [7:0] w_half_spm;
    logic [7:0] w_norm_sec_up;
    logic [7:0] w_norm_min_up;
    logic [7:0] w_fast_sec_up;
    logic [7:0] w_fast_min_up;

    assign w_norm_tick_inc = i_state.norm_tick + 8'd1;
    assign w_fast_tick_inc = i_state.fast_tick + 8'd1;
    assign w_fast_term     = {1'b0, i_cfg.ticks_per_second[7:1]};
    assign w_half_spm      = {1'b0, i_cfg.secs_per_minute[7:1]};
    assign w_norm_sec_up   = wrap_up(i_state.norm_sec, i_cfg.secs_per_minute);
    assign w_norm_min_up   = wrap_up(i_state.norm_min, i_cfg.mins_per_hour);
    assign w_fast_sec_up   = wrap_up(i_state.fast_sec, i_cfg.secs_per_minute);
    assign w_fast_min_up   = wrap_up(i_state.fast_min, i_cfg.mins_per_hour);

    always_comb begin
        o_state = i_state;
        o_flags = '{run_pulse: 1'b0, save_pulse: 1'b0, wcode: RTC_WR_NONE};

        unique case (i_command)
            CMD_TICK: begin
                // normal chain
                o_state.norm_tick = w_norm_tick_inc;
                if (w_norm_tick_inc == i_cfg.ticks_per_second) begin
                    o_state.norm_tick = 8'd0;
                    o_flags.run_pulse = ((i_state.norm_sec % RUN_TIME_DIVIDER) == 0);
                    o_state.norm_sec  = w_norm_sec_up;
                    if (w_norm_sec_up == 8'd0) begin
                        // minute rollover: nudge tick phase toward external clock
                        if (i_rtc_seconds != 8'd0) begin
                            o_state.norm_tick = (i_rtc_seconds > w_half_spm) ? 8'hFF : 8'd1;
                        end
                        o_state.norm_min = w_norm_min_up;
                        if (w_norm_min_up == 8'd0) begin
                            o_flags.save_pulse = 1'b1;
                            o_state.norm_hour  = wrap_up(i_state.norm_hour,
                                                         i_cfg.hours_per_day);
                        end
                    end
                end
                // double-speed chain
                o_state.fast_tick = w_fast_tick_inc;
                if (w_fast_tick_inc == w_fast_term) begin
                    o_state.fast_tick = 8'd0;
                    o_state.fast_sec  = w_fast_sec_up;
                    if (w_fast_sec_up == 8'd0) begin
                        o_state.fast_min = w_fast_min_up;
                        if (w_fast_min_up == 8'd0) begin
                            o_state.fast_hour = wrap_up(i_state.fast_hour,
                                                        i_cfg.hours_per_day);
                        end
                    end
                end
            end
            CMD_HOUR_INC: begin
                if (i_cfg.set_trick_mode) begin
                    o_state.fast_hour = wrap_up(i_state.fast_hour, i_cfg.hours_per_day);
                end else begin
                    o_state.norm_hour = wrap_up(i_state.norm_hour, i_cfg.hours_per_day);
                    o_flags.wcode     = RTC_WR_HOURS;
                end
            end
            CMD_HOUR_DEC: begin
                if (i_cfg.set_trick_mode) begin
                    o_state.fast_hour = wrap_down(i_state.fast_hour, i_cfg.hours_per_day);
                end else begin
                    o_state.norm_hour = wrap_down(i_state.norm_hour, i_cfg.hours_per_day);
                    o_flags.wcode     = RTC_WR_HOURS;
                end
            end
            CMD_MIN_INC: begin
                if (i_cfg.set_trick_mode) begin
                    o_state.fast_min = w_fast_min_up;
                end else begin
                    o_state.norm_min = w_norm_min_up;
                    o_flags.wcode    = RTC_WR_MINS;
                end
            end
            CMD_SEC_CLR: begin
                o_state.norm_sec  = 8'd0;
                o_state.norm_tick = 8'd0;
                o_flags.wcode     = RTC_WR_SECS;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/dual_rate_time_of_day_counter_core.sv =====
// ----------------------------------------------------------------------------
// dual_rate_time_of_day_counter_core
// Normal and double-speed tick/second/minute/hour counters with RTC resync.
// ----------------------------------------------------------------------------
// Each transfer on the input channel (a tick or a set command) yields exactly
// one transfer on the output channel carrying both times after the item, the
// running-time pulse, the hourly save pulse and the external clock write
// code. Unless the output stalls, the block sustains one item per clock: the
// item sits in an input register, the next-state logic updates the counter
// registers and the status register in one pass, and the counter registers
// themselves serve as the result time fields. The result is valid once they
// hold its item. Both registers advance whenever the result register is
// empty or its result is being taken, so a stalled output backs up through
// at most two items before o_in_ready drops. Configuration writes take
// effect on the next clock; change them only while no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_rate_time_of_day_counter_core
    import dtc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_command,
    input  logic [7:0] i_rtc_seconds,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_norm_hours,
    output logic [7:0] o_norm_minutes,
    output logic [7:0] o_norm_seconds,
    output logic [7:0] o_fast_hours,
    output logic [7:0] o_fast_minutes,
    output logic [7:0] o_fast_seconds,
    output logic       o_run_time_pulse,
    output logic       o_hourly_save_pulse,
    output logic [1:0] o_rtc_write_code
);

    // configuration
    t_cfg       r_cfg;

    // input register
    logic       r_in_valid;
    logic [2:0] r_command;
    logic [7:0] r_rtc_seconds;

    // counter state doubles as the result's time fields
    t_tod_state r_state;
    t_tod_state n_state;
    t_flags     r_flags;
    t_flags     n_flags;
    logic       r_out_valid;

    logic       w_advance;   // result register may load this cycle

    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_advance;

    dtc_next u_next (
        .i_cfg         (r_cfg),
        .i_state       (r_state),
        .i_command     (r_command),
        .i_rtc_seconds (r_rtc_seconds),
        .o_state       (n_state),
        .o_flags       (n_flags)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{ticks_per_second: 8'd64, secs_per_minute: 8'd60,
                       mins_per_hour: 8'd60, hours_per_day: 8'd24,
                       set_trick_mode: 1'b0};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICKS_PER_SEC: r_cfg.ticks_per_second <= i_cfg_data;
                CFG_SECS_PER_MIN:  r_cfg.secs_per_minute  <= i_cfg_data;
                CFG_MINS_PER_HOUR: r_cfg.mins_per_hour    <= i_cfg_data;
                CFG_HOURS_PER_DAY: r_cfg.hours_per_day    <= i_cfg_data;
                CFG_TRICK_MODE:    r_cfg.set_trick_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // control and counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_command     <= i_command;
            r_rtc_seconds <= i_rtc_seconds;
        end
        if (w_advance && r_in_valid) begin
            r_flags <= n_flags;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_norm_hours        = r_state.norm_hour;
    assign o_norm_minutes      = r_state.norm_min;
    assign o_norm_seconds      = r_state.norm_sec;
    assign o_fast_hours        = r_state.fast_hour;
    assign o_fast_minutes      = r_state.fast_min;
    assign o_fast_seconds      = r_state.fast_sec;
    assign o_run_time_pulse    = r_flags.run_pulse;
    assign o_hourly_save_pulse = r_flags.save_pulse;
    assign o_rtc_write_code    = r_flags.wcode;

endmodule

`default_nettype wire

// ===== hdl/dtc_checker.sv =====
// ----------------------------------------------------------------------------
// dtc_checker
// Port-level checks for the dual-rate time-of-day counter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dtc_checker
    import dtc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_norm_minutes,
    input logic [7:0] o_norm_seconds,
    input logic       o_run_time_pulse,
    input logic       o_hourly_save_pulse,
    input logic [1:0] o_rtc_write_code
);

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // hourly save only on a tick that wrapped seconds and minutes
    a_save_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hourly_save_pulse |->
            o_run_time_pulse && o_norm_minutes == 8'd0 && o_norm_seconds == 8'd0
            && o_rtc_write_code == RTC_WR_NONE)
        else $error("hourly save without minute wrap");

    // set commands never pulse the metrics
    a_set_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rtc_write_code != RTC_WR_NONE |->
            !o_run_time_pulse && !o_hourly_save_pulse)
        else $error("metric pulse on a set command");

    // clear seconds leaves normal seconds at zero
    a_clear_secs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rtc_write_code == RTC_WR_SECS |-> o_norm_seconds == 8'd0)
        else $error("seconds not cleared");

endmodule

bind dual_rate_time_of_day_counter_core dtc_checker u_dtc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_norm_minutes      (o_norm_minutes),
    .o_norm_seconds      (o_norm_seconds),
    .o_run_time_pulse    (o_run_time_pulse),
    .o_hourly_save_pulse (o_hourly_save_pulse),
    .o_rtc_write_code    (o_rtc_write_code)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual-rate time-of-day counter core.
// ----------------------------------------------------------------------------
// Items go in over the valid/ready input channel. A cycle-free software copy
// of both counter cascades predicts the reading for every accepted item. A
// monitor process pops those predictions in order and compares each result
// transfer field by field. The run covers directed set commands, resync at
// minute rollover, tick counters left past their terminal value, limit and
// divider extremes, random settings, random idling on both sides and a long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------

module testbench;
    import dtc_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int IDLE_PCT      = 17;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_PRINTED   = 40;

    // Command values with no function; the block must report times unchanged.
    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [7:0] norm_hours;
        logic [7:0] norm_minutes;
        logic [7:0] norm_seconds;
        logic [7:0] fast_hours;
        logic [7:0] fast_minutes;
        logic [7:0] fast_seconds;
        t_flags     flags;
    } t_tod_reading;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [2:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_command;
    logic [7:0] i_rtc_seconds;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_norm_hours;
    logic [7:0] o_norm_minutes;
    logic [7:0] o_norm_seconds;
    logic [7:0] o_fast_hours;
    logic [7:0] o_fast_minutes;
    logic [7:0] o_fast_seconds;
    logic       o_run_time_pulse;
    logic       o_hourly_save_pulse;
    logic [1:0] o_rtc_write_code;

    // Bench copy of the block's settings and counters
    t_cfg       clock_cfg;
    t_tod_state clock_time;

    t_tod_reading expected_readings[$];
    int           mismatches    = 0;
    int           results_seen  = 0;
    int           cycle_count   = 0;
    int           sink_hold_left = 0;
    bit           src_gaps_on   = 1'b1;
    bit           sink_gaps_on  = 1'b1;

    dual_rate_time_of_day_counter_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_rtc_seconds      (i_rtc_seconds),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_norm_hours       (o_norm_hours),
        .o_norm_minutes     (o_norm_minutes),
        .o_norm_seconds     (o_norm_seconds),
        .o_fast_hours       (o_fast_hours),
        .o_fast_minutes     (o_fast_minutes),
        .o_fast_seconds     (o_fast_seconds),
        .o_run_time_pulse   (o_run_time_pulse),
        .o_hourly_save_pulse(o_hourly_save_pulse),
        .o_rtc_write_code   (o_rtc_write_code)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d readings pending",
                     cycle_count, expected_readings.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Counter arithmetic: 8-bit step, then clear (up) or clamp (down) against
    // the limit. A zero limit pins an up-counter at zero.
    // ------------------------------------------------------------------------
    function automatic logic [7:0] bump_wrap(input logic [7:0] v, input logic [7:0] lim);
        logic [7:0] n;
        n = v + 8'd1;
        if (n >= lim)
            n = 8'd0;
        return n;
    endfunction

    function automatic logic [7:0] drop_wrap(input logic [7:0] v, input logic [7:0] lim);
        logic [7:0] n;
        n = v - 8'd1;
        if (n >= lim)
            n = lim - 8'd1;
        return n;
    endfunction

    // Advances the bench copy of both cascades by one item and returns the
    // reading the block must produce for it.
    function automatic t_tod_reading advance_clock(input logic [2:0] cmd,
                                                   input logic [7:0] rtc);
        t_tod_reading r;
        logic [7:0]   fast_terminal;
        logic [7:0]   half_minute;
        r.flags       = '0;
        r.flags.wcode = RTC_WR_NONE;
        fast_terminal = clock_cfg.ticks_per_second >> 1;
        half_minute   = clock_cfg.secs_per_minute >> 1;
        case (cmd)
            CMD_TICK: begin
                // Equality compare only: a count past the terminal runs on
                // through 256 before it matches again.
                clock_time.norm_tick = clock_time.norm_tick + 8'd1;
                if (clock_time.norm_tick == clock_cfg.ticks_per_second) begin
                    clock_time.norm_tick = 8'd0;
                    if (clock_time.norm_sec % RUN_TIME_DIVIDER == 0)
                        r.flags.run_pulse = 1'b1;
                    clock_time.norm_sec = bump_wrap(clock_time.norm_sec,
                                                    clock_cfg.secs_per_minute);
                    if (clock_time.norm_sec == 8'd0) begin
                        // Resync nudge against the external seconds reading
                        if (rtc != 8'd0) begin
                            if (rtc > half_minute)
                                clock_time.norm_tick = clock_time.norm_tick - 8'd1;
                            else
                                clock_time.norm_tick = clock_time.norm_tick + 8'd1;
                        end
                        clock_time.norm_min = bump_wrap(clock_time.norm_min,
                                                        clock_cfg.mins_per_hour);
                        if (clock_time.norm_min == 8'd0) begin
                            r.flags.save_pulse = 1'b1;
                            clock_time.norm_hour = bump_wrap(clock_time.norm_hour,
                                                             clock_cfg.hours_per_day);
                        end
                    end
                end
                clock_time.fast_tick = clock_time.fast_tick + 8'd1;
                if (clock_time.fast_tick == fast_terminal) begin
                    clock_time.fast_tick = 8'd0;
                    clock_time.fast_sec = bump_wrap(clock_time.fast_sec,
                                                    clock_cfg.secs_per_minute);
                    if (clock_time.fast_sec == 8'd0) begin
                        clock_time.fast_min = bump_wrap(clock_time.fast_min,
                                                        clock_cfg.mins_per_hour);
                        if (clock_time.fast_min == 8'd0)
                            clock_time.fast_hour = bump_wrap(clock_time.fast_hour,
                                                             clock_cfg.hours_per_day);
                    end
                end
            end
            CMD_HOUR_INC: begin
                if (clock_cfg.set_trick_mode) begin
                    clock_time.fast_hour = bump_wrap(clock_time.fast_hour,
                                                     clock_cfg.hours_per_day);
                end else begin
                    clock_time.norm_hour = bump_wrap(clock_time.norm_hour,
                                                     clock_cfg.hours_per_day);
                    r.flags.wcode = RTC_WR_HOURS;
                end
            end
            CMD_HOUR_DEC: begin
                if (clock_cfg.set_trick_mode) begin
                    clock_time.fast_hour = drop_wrap(clock_time.fast_hour,
                                                     clock_cfg.hours_per_day);
                end else begin
                    clock_time.norm_hour = drop_wrap(clock_time.norm_hour,
                                                     clock_cfg.hours_per_day);
                    r.flags.wcode = RTC_WR_HOURS;
                end
            end
            CMD_MIN_INC: begin
                if (clock_cfg.set_trick_mode) begin
                    clock_time.fast_min = bump_wrap(clock_time.fast_min,
                                                    clock_cfg.mins_per_hour);
                end else begin
                    clock_time.norm_min = bump_wrap(clock_time.norm_min,
                                                    clock_cfg.mins_per_hour);
                    r.flags.wcode = RTC_WR_MINS;
                end
            end
            CMD_SEC_CLR: begin
                // Always the normal chain, whatever the set mode
                clock_time.norm_sec  = 8'd0;
                clock_time.norm_tick = 8'd0;
                r.flags.wcode = RTC_WR_SECS;
            end
            default: ;  // spare codes: report only
        endcase
        r.norm_hours   = clock_time.norm_hour;
        r.norm_minutes = clock_time.norm_min;
        r.norm_seconds = clock_time.norm_sec;
        r.fast_hours   = clock_time.fast_hour;
        r.fast_minutes = clock_time.fast_min;
        r.fast_seconds = clock_time.fast_sec;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH t=%0t result %0d: %s got %0d want %0d",
                     $time, results_seen, what, got, want);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // Ready: long hold-off first, then random stalls
    always @(negedge i_clk) begin
        if (sink_hold_left > 0) begin
            i_out_ready <= 1'b0;
            sink_hold_left = sink_hold_left - 1;
        end else if (sink_gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest pending reading
    always @(posedge i_clk) begin
        t_tod_reading want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_readings.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                want = expected_readings.pop_front();
                check_field("norm_hours",   o_norm_hours,   want.norm_hours);
                check_field("norm_minutes", o_norm_minutes, want.norm_minutes);
                check_field("norm_seconds", o_norm_seconds, want.norm_seconds);
                check_field("fast_hours",   o_fast_hours,   want.fast_hours);
                check_field("fast_minutes", o_fast_minutes, want.fast_minutes);
                check_field("fast_seconds", o_fast_seconds, want.fast_seconds);
                check_field("run_time_pulse", 8'(o_run_time_pulse),
                            8'(want.flags.run_pulse));
                check_field("hourly_save_pulse", 8'(o_hourly_save_pulse),
                            8'(want.flags.save_pulse));
                check_field("rtc_write_code", 8'(o_rtc_write_code),
                            8'(want.flags.wcode));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one item and hold it until the transfer; prediction is queued at
    // the accepting edge. Valid stays high on return so items can stream.
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] rtc);
        @(negedge i_clk);
        while (src_gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_rtc_seconds <= rtc;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        expected_readings.push_back(advance_clock(cmd, rtc));
    endtask

    // Mostly ticks; rtc readings split between zero, early and anywhere
    task automatic send_random_item();
        int         pick;
        logic [2:0] cmd;
        logic [7:0] rtc;
        pick = $urandom_range(99);
        if (pick < 65)      cmd = CMD_TICK;
        else if (pick < 72) cmd = CMD_HOUR_INC;
        else if (pick < 78) cmd = CMD_HOUR_DEC;
        else if (pick < 85) cmd = CMD_MIN_INC;
        else if (pick < 91) cmd = CMD_SEC_CLR;
        else                cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
        case ($urandom_range(3))
            0:       rtc = 8'd0;
            1:       rtc = 8'($urandom_range(clock_cfg.secs_per_minute >> 1));
            default: rtc = 8'($urandom_range(255));
        endcase
        send_item(cmd, rtc);
    endtask

    // Drop valid and wait for every pending reading, then let the pipe settle
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called with nothing in flight
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_TICKS_PER_SEC: clock_cfg.ticks_per_second = data;
            CFG_SECS_PER_MIN:  clock_cfg.secs_per_minute  = data;
            CFG_MINS_PER_HOUR: clock_cfg.mins_per_hour    = data;
            CFG_HOURS_PER_DAY: clock_cfg.hours_per_day    = data;
            CFG_TRICK_MODE:    clock_cfg.set_trick_mode   = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(input logic [7:0] tps, input logic [7:0] spm,
                                  input logic [7:0] mph, input logic [7:0] hpd,
                                  input logic trick);
        wait_results_drained();
        write_reg(CFG_TICKS_PER_SEC, tps);
        write_reg(CFG_SECS_PER_MIN,  spm);
        write_reg(CFG_MINS_PER_HOUR, mph);
        write_reg(CFG_HOURS_PER_DAY, hpd);
        write_reg(CFG_TRICK_MODE,    {7'd0, trick});
    endtask

    task automatic run_random_phase(input logic [7:0] tps, input logic [7:0] spm,
                                    input logic [7:0] mph, input logic [7:0] hpd,
                                    input logic trick, input int count);
        apply_settings(tps, spm, mph, hpd, trick);
        repeat (count) send_random_item();
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every command in both set modes from the reset settings, then a few
    // ticks with all limits at two, one of them a rollover with a late reading.
    task automatic test_set_commands();
        send_item(CMD_HOUR_DEC, 8'd0);      // below zero clamps to hours-1
        send_item(CMD_HOUR_INC, 8'd0);      // wraps back to zero
        send_item(CMD_HOUR_INC, 8'hFF);
        send_item(CMD_MIN_INC,  8'd0);
        send_item(CMD_SEC_CLR,  8'd0);
        send_item(CMD_SPARE_5,  8'hAA);
        send_item(CMD_SPARE_6,  8'h55);
        send_item(CMD_SPARE_7,  8'hFF);
        send_item(CMD_TICK,     8'hFF);
        send_item(CMD_TICK,     8'd0);
        wait_results_drained();
        write_reg(CFG_TRICK_MODE, 8'd1);
        send_item(CMD_HOUR_INC, 8'd0);
        send_item(CMD_HOUR_DEC, 8'd0);
        send_item(CMD_HOUR_DEC, 8'd0);
        send_item(CMD_MIN_INC,  8'd0);
        send_item(CMD_SEC_CLR,  8'd0);      // normal chain even in trick mode
        send_item(CMD_TICK,     8'd0);
        apply_settings(8'd2, 8'd2, 8'd2, 8'd2, 1'b0);
        send_item(CMD_TICK, 8'd1);
        send_item(CMD_TICK, 8'd1);          // no minute rollover, reading unused
        send_item(CMD_TICK, 8'd2);
        send_item(CMD_TICK, 8'd2);          // after the late-reading rollover (-1)
        send_item(CMD_TICK, 8'd0);
        send_item(CMD_TICK, 8'd0);
    endtask

    // Lower the tick terminal below the live count, and drop to a single tick
    // per second so the fast terminal is zero (one fast step per 256 ticks).
    task automatic test_terminal_passed();
        apply_settings(8'd6, 8'd3, 8'd2, 8'd3, 1'b0);
        repeat (5) send_item(CMD_TICK, 8'd0);
        wait_results_drained();
        write_reg(CFG_TICKS_PER_SEC, 8'd1);
        repeat (262) send_item(CMD_TICK, 8'($urandom_range(255)));
    endtask

    // Limits at both ends, including zero limits that pin up-steps at zero
    task automatic test_config_extremes();
        run_random_phase(8'd2,   8'd1,   8'd1,   8'd1,   1'b0, 10);
        run_random_phase(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 10);
        run_random_phase(8'd3,   8'd0,   8'd0,   8'd0,   1'b0, 10);
    endtask

    // Small random settings so every cascade rolls over often; one longer
    // phase runs with no idling on either side.
    task automatic test_random_settings();
        for (int p = 0; p < 5; p++) begin
            src_gaps_on  = (p != 2);
            sink_gaps_on = (p != 2);
            run_random_phase(8'($urandom_range(2, 6)), 8'($urandom_range(1, 6)),
                             8'($urandom_range(1, 4)), 8'($urandom_range(1, 5)),
                             1'($urandom_range(1)), (p == 2) ? 40 : 15);
        end
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    // Hold the output off while the sender streams, so the block fills and
    // drops its input ready.
    task automatic test_output_backpressure();
        apply_settings(8'd4, 8'd3, 8'd2, 8'd4, 1'b0);
        src_gaps_on = 1'b0;
        @(posedge i_clk);
        sink_hold_left = HOLD_CYCLES;
        repeat (30) send_random_item();
        src_gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_TICKS_PER_SEC;
        i_cfg_data    = 8'd0;
        i_in_valid    = 1'b0;
        i_command     = CMD_TICK;
        i_rtc_seconds = 8'd0;
        i_out_ready   = 1'b0;

        clock_cfg.ticks_per_second = 8'd64;
        clock_cfg.secs_per_minute  = 8'd60;
        clock_cfg.mins_per_hour    = 8'd60;
        clock_cfg.hours_per_day    = 8'd24;
        clock_cfg.set_trick_mode   = 1'b0;
        clock_time                 = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_set_commands();
        test_terminal_passed();
        test_config_extremes();
        test_random_settings();
        test_output_backpressure();
        wait_results_drained();

        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
